/* hw/rtl/tcw_pkg.sv */
// Text console writer package: controller states, command/status bundles,
// character codes and cell constants. No dependencies.
package tcw_pkg;

  localparam logic [7:0]  CODE_SPACE   = 8'd32;
  localparam logic [7:0]  CODE_NEWLINE = 8'd10;
  localparam logic [7:0]  CODE_RETURN  = 8'd13;
  localparam logic [7:0]  CODE_TAB     = 8'd9;
  localparam logic [15:0] CELL_RESET   = 16'h0720;  // blank, grey on black
  localparam logic [7:0]  COLOR_RESET  = 8'd7;
  localparam logic        MODE_PUT     = 1'b0;
  localparam logic        MODE_READ    = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_NEWLINE,
    ST_COPY,
    ST_FILL,
    ST_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;  // write reset cell at sweep counter
    logic accept;      // latch request, issue cell read
    logic put;         // write char at cursor, advance cursor
    logic newline;     // cursor to column 0 of next row
    logic copy_step;   // scroll: move one cell up a line
    logic fill_step;   // scroll: blank one cell of bottom line
    logic finish;      // load result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_read;     // incoming request is a cell read
    logic in_break;    // incoming request is newline or return
    logic col_last;
    logic row_last;
    logic rem_last;    // one put left for this request
    logic rem_zero;    // no put left for this request
    logic copy_end;    // sweep counter at end of copy
    logic cnt_end;     // sweep counter at last cell
    logic out_free;    // result register can take a new result
  } dp_status_t;

endpackage

/* hw/rtl/text_console_writer_unit.sv */
// Text console writer top level: stream ports, config port, controller and
// datapath. Depends on tcw_pkg, tcw_ctrl, tcw_datapath.
//
// Usage: requests enter on the s_axis channel. tuser selects the kind: 0 puts
// char_code at the cursor (newline and return go to column 0 of the next row,
// tab puts TAB_SPACES spaces), 1 reads the cell at cell_index. Every request
// gives one result on m_axis with the cursor after the request, the read cell
// (zero for puts and out-of-range reads) and a scroll flag.
// Scroll: the cell store, with one read and one write port, moves one cell
// per cycle up a line, then blanks the bottom line in the current color.
// Reset: the cursor goes home, the color to grey on black, and a clearing
// pass writes a blank to every cell with s_axis_tready low. Color writes
// (cfg_we_i) are taken at any time and apply to cells written after them.
// Stall: the result sits in an output register; one further request can be
// accepted and worked while it waits, and its result holds until taken.
module text_console_writer_unit #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // color register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // request channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] char_code, [18:8] cell_index, rest zero
  input  logic        s_axis_tuser_i,   // [0] mode
  // result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [4:0] cursor_row, [11:5] cursor_col,
                                        // [27:12] cell_data, [28] did_scroll
);

  tcw_pkg::ctrl_cmd_t  cmd;
  tcw_pkg::dp_status_t status;

  logic [4:0]  out_row;
  logic [6:0]  out_col;
  logic [15:0] out_data;
  logic        out_scroll;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .TAB_SPACES (TAB_SPACES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mode_i    (s_axis_tuser_i),
    .in_char_i    (s_axis_tdata_i[7:0]),
    .in_index_i   (s_axis_tdata_i[18:8]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .out_data_o   (out_data),
    .out_scroll_o (out_scroll)
  );

  assign m_axis_tdata_o = {3'b000, out_scroll, out_data, out_col, out_row};

endmodule

/* hw/rtl/tcw_ctrl.sv */
// Text console writer controller: sequences clear, put, newline, scroll and
// result hand-off. Depends on tcw_pkg.
module tcw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tcw_pkg::dp_status_t   status_i,
  output tcw_pkg::ctrl_cmd_t    cmd_o
);

  tcw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        if (status_i.cnt_end) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          priority if (status_i.in_read) state_d = tcw_pkg::ST_FINISH;
          else if (status_i.in_break)    state_d = tcw_pkg::ST_NEWLINE;
          else                           state_d = tcw_pkg::ST_PUT;
        end
      end
      tcw_pkg::ST_PUT: begin
        priority if (status_i.col_last && status_i.row_last) state_d = tcw_pkg::ST_COPY;
        else if (status_i.rem_last)                           state_d = tcw_pkg::ST_FINISH;
        else                                                  state_d = tcw_pkg::ST_PUT;
      end
      tcw_pkg::ST_NEWLINE: begin
        state_d = status_i.row_last ? tcw_pkg::ST_COPY : tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_COPY: begin
        if (status_i.copy_end) state_d = tcw_pkg::ST_FILL;
      end
      tcw_pkg::ST_FILL: begin
        if (status_i.cnt_end) begin
          state_d = status_i.rem_zero ? tcw_pkg::ST_FINISH : tcw_pkg::ST_PUT;
        end
      end
      tcw_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = tcw_pkg::ST_IDLE;
      end
      default: state_d = tcw_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tcw_pkg::ST_CLEAR:   cmd_o.clear_step = 1'b1;
      tcw_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      tcw_pkg::ST_PUT:     cmd_o.put       = 1'b1;
      tcw_pkg::ST_NEWLINE: cmd_o.newline   = 1'b1;
      tcw_pkg::ST_COPY:    cmd_o.copy_step = 1'b1;
      tcw_pkg::ST_FILL:    cmd_o.fill_step = 1'b1;
      tcw_pkg::ST_FINISH:  cmd_o.finish    = status_i.out_free;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/tcw_datapath.sv */
// Text console writer datapath: cursor, cell store, sweep counter, color
// register and result register. Depends on tcw_pkg.
module tcw_datapath #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  in_mode_i,
  input  logic [7:0]            in_char_i,
  input  logic [10:0]           in_index_i,
  input  tcw_pkg::ctrl_cmd_t    cmd_i,
  output tcw_pkg::dp_status_t   status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [4:0]            out_row_o,
  output logic [6:0]            out_col_o,
  output logic [15:0]           out_data_o,
  output logic                  out_scroll_o
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int NCOPY      = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int REM_W      = $clog2(TAB_SPACES + 1);

  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CNT_LAST  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(NCOPY);
  localparam logic [ADDR_W-1:0] LINE_LEN  = ADDR_W'(COLUMNS);

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [7:0]        color_q;
  logic              scrolled_q, scrolled_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic              mode_q, tab_q, in_range_q;
  logic [7:0]        char_q;

  logic              out_valid_q;
  logic [4:0]        out_row_q;
  logic [6:0]        out_col_q;
  logic [15:0]       out_data_q;
  logic              out_scroll_q;

  logic [15:0]       mem_q [CELL_COUNT];
  logic [15:0]       rd_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [15:0]       mem_wd;

  logic [ADDR_W-1:0] cur_addr;
  logic              in_range;
  logic              in_tab, in_break;
  logic [7:0]        put_char;

  assign cur_addr = ADDR_W'(ADDR_W'(row_q) * LINE_LEN + ADDR_W'(col_q));
  assign in_range = 32'(in_index_i) < 32'(CELL_COUNT);
  assign in_tab   = (in_char_i == tcw_pkg::CODE_TAB);
  assign in_break = (in_char_i == tcw_pkg::CODE_NEWLINE) ||
                    (in_char_i == tcw_pkg::CODE_RETURN);
  assign put_char = tab_q ? tcw_pkg::CODE_SPACE : char_q;

  // status
  always_comb begin
    status_o.in_read  = (in_mode_i == tcw_pkg::MODE_READ);
    status_o.in_break = in_break;
    status_o.col_last = (col_q == COL_LAST);
    status_o.row_last = (row_q == ROW_LAST);
    status_o.rem_last = (rem_q == REM_W'(1));
    status_o.rem_zero = (rem_q == '0);
    status_o.copy_end = (cnt_q == COPY_END);
    status_o.cnt_end  = (cnt_q == CNT_LAST);
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  // cursor, counters, scroll flag
  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    cnt_d      = cnt_q;
    scrolled_d = scrolled_q;
    rem_d      = rem_q;
    if (cmd_i.accept) begin
      scrolled_d = 1'b0;
      priority if (in_tab) rem_d = REM_W'(TAB_SPACES);
      else if (in_break)   rem_d = '0;
      else                 rem_d = REM_W'(1);
    end
    if (cmd_i.put || cmd_i.newline) begin
      if (cmd_i.newline || col_q == COL_LAST) begin
        col_d = '0;
        if (row_q == ROW_LAST) begin
          scrolled_d = 1'b1;
          cnt_d      = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
    if (cmd_i.put) rem_d = rem_q - REM_W'(1);
    if (cmd_i.copy_step && cnt_q != COPY_END) cnt_d = cnt_q + ADDR_W'(1);
    if (cmd_i.clear_step || cmd_i.fill_step) begin
      cnt_d = (cnt_q == CNT_LAST) ? '0 : cnt_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      scrolled_q  <= 1'b0;
      rem_q       <= '0;
      color_q     <= tcw_pkg::COLOR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      cnt_q      <= cnt_d;
      scrolled_q <= scrolled_d;
      rem_q      <= rem_d;
      if (cfg_we_i) color_q <= cfg_wdata_i;
      if (cmd_i.finish)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q     <= in_mode_i;
      char_q     <= in_char_i;
      tab_q      <= in_tab;
      in_range_q <= in_range;
    end
    if (cmd_i.finish) begin
      out_row_q    <= 5'(row_q);
      out_col_q    <= 7'(col_q);
      out_data_q   <= (mode_q == tcw_pkg::MODE_READ && in_range_q) ? rd_q : '0;
      out_scroll_q <= (mode_q == tcw_pkg::MODE_PUT) && scrolled_q;
    end
  end

  // cell store port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_q;
    mem_wd = tcw_pkg::CELL_RESET;
    mem_re = 1'b0;
    mem_ra = ADDR_W'(in_index_i);
    priority if (cmd_i.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.put) begin
      mem_we = 1'b1;
      mem_wa = cur_addr;
      mem_wd = {color_q, put_char};
    end else if (cmd_i.copy_step) begin
      // read runs one cell ahead of the write
      mem_re = (cnt_q != COPY_END);
      mem_ra = ADDR_W'(cnt_q + LINE_LEN);
      mem_we = (cnt_q != '0);
      mem_wa = ADDR_W'(cnt_q - ADDR_W'(1));
      mem_wd = rd_q;
    end else if (cmd_i.fill_step) begin
      mem_we = 1'b1;
      mem_wd = {color_q, tcw_pkg::CODE_SPACE};
    end else if (cmd_i.accept) begin
      mem_re = (in_mode_i == tcw_pkg::MODE_READ) && in_range;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem_q[mem_ra];
  end

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign out_data_o   = out_data_q;
  assign out_scroll_o = out_scroll_q;

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < ROWS) else $error("cursor row out of range");
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < COLUMNS) else $error("cursor column out of range");
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.clear_step, cmd_i.put, cmd_i.copy_step, cmd_i.fill_step}))
    else $error("more than one store writer");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q) else $error("result lost");

endmodule

/* verif/text_console_writer_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for text_console_writer_unit: puts, reads, wraps, scrolls, color writes.
// Holds a cycle-free screen/cursor predictor; depends on tcw_pkg and the unit only.
module text_console_writer_unit_test;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_SPACES = 4;
  localparam int CELLS      = ROWS * COLUMNS;
  // no-handshake limit: above the clearing pass, one scroll and the receiver hold-off
  localparam int QUIET_LIMIT = 20000;
  // settle time at the end: one full scroll plus margin
  localparam int TAIL_CYCLES = CELLS + 200;

  // one result as the unit reports it
  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [15:0] cell_word;
    logic        scrolled;
  } cursor_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        s_valid;
  logic        s_ready;
  logic [23:0] s_data;   // [7:0] char_code, [18:8] cell_index
  logic        s_user;   // [0] mode
  logic        m_valid;
  logic        m_ready;
  logic [31:0] m_data;   // [4:0] row, [11:5] col, [27:12] cell, [28] scroll

  text_console_writer_unit #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_SPACES(TAB_SPACES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: screen copy, cursor and color
  // ---------------------------------------------------------------------------
  logic [15:0]    screen_q [CELLS];
  int unsigned    cur_row;
  int unsigned    cur_col;
  logic [7:0]     color_q;
  cursor_report_t cursor_reports [$];   // results still owed by the unit

  // shared control
  bit steady;          // no idling on either side
  int hold_request;    // receiver hold-off length, picked up by the receiver
  int error_count;
  int quiet_cycles;
  int put_count, read_count, checked_count, scroll_count;

  // shift the screen up one line, bottom line blanks in the current color
  function automatic void scroll_screen();
    for (int i = 0; i + COLUMNS < CELLS; i++) screen_q[i] = screen_q[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      screen_q[i] = {color_q, tcw_pkg::CODE_SPACE};
    end
  endfunction

  function automatic bit move_to_next_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      cur_row = ROWS - 1;
      scroll_screen();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit write_char_at_cursor(logic [7:0] ch);
    screen_q[cur_row * COLUMNS + cur_col] = {color_q, ch};
    cur_col++;
    if (cur_col >= COLUMNS) return move_to_next_line();
    return 1'b0;
  endfunction

  // expected result of one request; updates screen and cursor
  function automatic cursor_report_t apply_request(logic mode, logic [7:0] ch,
                                                   logic [10:0] idx);
    cursor_report_t r;
    r = '0;
    if (mode == tcw_pkg::MODE_READ) begin
      // out-of-range reads return zero
      if (idx < CELLS) r.cell_word = screen_q[idx];
    end else if (ch == tcw_pkg::CODE_NEWLINE || ch == tcw_pkg::CODE_RETURN) begin
      r.scrolled = move_to_next_line();
    end else if (ch == tcw_pkg::CODE_TAB) begin
      // each space may wrap and scroll on its own
      for (int k = 0; k < TAB_SPACES; k++) begin
        if (write_char_at_cursor(tcw_pkg::CODE_SPACE)) r.scrolled = 1'b1;
      end
    end else begin
      r.scrolled = write_char_at_cursor(ch);
    end
    r.row = cur_row[4:0];
    r.col = cur_col[6:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, receiver, checker, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls, steady stretches, and counted hold-offs.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= steady || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // Result checker: compare each taken result with the oldest expectation.
  always @(posedge clk_i) begin
    cursor_report_t got, want;
    if (rst_ni && m_valid && m_ready) begin
      got.row       = m_data[4:0];
      got.col       = m_data[11:5];
      got.cell_word = m_data[27:12];
      got.scrolled  = m_data[28];
      if (got.scrolled) scroll_count++;
      if (cursor_reports.size() == 0) begin
        $error("result with nothing expected: 0x%08h", m_data);
        error_count++;
      end else begin
        want = cursor_reports.pop_front();
        checked_count++;
        if (got.row != want.row) begin
          $error("cursor_row: expected %0d, got %0d", want.row, got.row);
          error_count++;
        end
        if (got.col != want.col) begin
          $error("cursor_col: expected %0d, got %0d", want.col, got.col);
          error_count++;
        end
        if (got.cell_word != want.cell_word) begin
          $error("cell_data: expected 0x%04h, got 0x%04h",
                 want.cell_word, got.cell_word);
          error_count++;
        end
        if (got.scrolled != want.scrolled) begin
          $error("did_scroll: expected %0d, got %0d", want.scrolled, got.scrolled);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side ends the run.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------
  // Offer one request, wait for it to be taken, record what it should return.
  task automatic send_request(input logic mode, input logic [7:0] ch,
                              input logic [10:0] idx);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 26) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= {5'b0, idx, ch};
    do @(posedge clk_i); while (!s_ready);
    cursor_reports.push_back(apply_request(mode, ch, idx));
    if (mode == tcw_pkg::MODE_READ) read_count++;
    else put_count++;
  endtask

  task automatic send_put(input logic [7:0] ch);
    send_request(tcw_pkg::MODE_PUT, ch, 11'($urandom_range(0, 2047)));
  endtask

  task automatic send_read(input int unsigned idx);
    send_request(tcw_pkg::MODE_READ, 8'($urandom_range(0, 255)), 11'(idx));
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic finish_phase();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (cursor_reports.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Color write; only called with the unit idle.
  task automatic write_color(input logic [7:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    color_q = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // plain codes at both ends, controls, tab, from the reset color
  task automatic test_basic_puts();
    send_put(8'h41);
    send_put(8'h00);
    send_put(8'hFF);
    send_put(tcw_pkg::CODE_TAB);
    send_put(8'h7A);
    send_put(tcw_pkg::CODE_RETURN);
    send_put(8'h80);
    send_put(tcw_pkg::CODE_NEWLINE);
    send_put(8'h7F);
    finish_phase();
  endtask

  // reads: first and last cell, just past the store, top of the index range
  task automatic test_cell_reads();
    send_read(0);
    send_read(1);
    send_read(COLUMNS);
    send_read(CELLS - 1);
    send_read(CELLS);
    send_read(2047);
    finish_phase();
  endtask

  // both color extremes land in the written cells
  task automatic test_color_extremes();
    write_color(8'hFF);
    send_put(8'h55);
    send_put(tcw_pkg::CODE_TAB);
    finish_phase();
    write_color(8'h00);
    send_put(8'hAA);
    send_read(cur_row * COLUMNS);
    finish_phase();
  endtask

  // walk down to the last row, then break there: scroll, cursor pinned at bottom
  task automatic test_bottom_row_scroll();
    write_color(8'h1E);
    while (cur_row != ROWS - 1) begin
      send_put(cur_row[0] ? tcw_pkg::CODE_RETURN : tcw_pkg::CODE_NEWLINE);
    end
    send_put(8'h23);
    send_put(tcw_pkg::CODE_NEWLINE);
    send_put(tcw_pkg::CODE_RETURN);
    send_read((ROWS - 1) * COLUMNS);       // freshly blanked line
    send_read((ROWS - 2) * COLUMNS);       // line moved up by the scroll
    send_read(0);
    finish_phase();
  endtask

  // receiver holds off while requests keep coming; the unit must stall its input
  task automatic test_output_backpressure();
    hold_request = 400;
    for (int i = 0; i < 40; i++) begin
      if (i % 5 == 4) send_read($urandom_range(0, CELLS - 1));
      else send_put(8'($urandom_range(0, 255)));
    end
    finish_phase();
  endtask

  // mostly puts and reads near the cursor; break_pct sets newline density
  task automatic test_random_traffic(input int count, input int break_pct,
                                     input int read_pct);
    int sel;
    int unsigned pos, back;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < read_pct) begin
        case ($urandom_range(0, 3))
          0, 1: begin
            // recently written cells
            pos  = cur_row * COLUMNS + cur_col;
            back = $urandom_range(1, 6);
            send_read(pos >= back ? pos - back : pos);
          end
          2: send_read($urandom_range(0, 2047));
          default: send_read($urandom_range(0, CELLS - 1));
        endcase
      end else if (sel < read_pct + break_pct) begin
        send_put($urandom_range(0, 1) ? tcw_pkg::CODE_NEWLINE : tcw_pkg::CODE_RETURN);
      end else if (sel < read_pct + break_pct + 4) begin
        send_put(tcw_pkg::CODE_TAB);
      end else begin
        send_put(8'($urandom_range(0, 255)));
      end
    end
    finish_phase();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    s_valid      = 1'b0;
    s_user       = 1'b0;
    s_data       = '0;
    steady       = 1'b0;
    hold_request = 0;
    error_count  = 0;
    quiet_cycles = 0;
    put_count    = 0;
    read_count   = 0;
    checked_count = 0;
    scroll_count = 0;
    foreach (screen_q[i]) screen_q[i] = tcw_pkg::CELL_RESET;
    cur_row = 0;
    cur_col = 0;
    color_q = tcw_pkg::COLOR_RESET;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_puts();
    test_cell_reads();
    test_color_extremes();
    test_bottom_row_scroll();
    test_output_backpressure();

    // sparse breaks: long lines, wraps and wrap-driven scrolls
    write_color(8'($urandom_range(0, 255)));
    test_random_traffic(440, 1, 25);
    // steady stretch, no idling on either side
    write_color(8'hFF);
    steady = 1'b1;
    test_random_traffic(440, 6, 30);
    steady = 1'b0;
    write_color(8'($urandom_range(0, 255)));
    test_random_traffic(440, 8, 30);
    write_color(8'h00);
    test_random_traffic(440, 3, 35);

    // catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d puts and %0d cell reads, %0d results checked, %0d scrolls",
             put_count, read_count, checked_count, scroll_count);
    $display("color extremes, bottom-row breaks, tab wraps and a 400-cycle output stall");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* text_console_writer_unit.f */
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_datapath.sv
hw/rtl/text_console_writer_unit.sv
verif/text_console_writer_unit_test.sv
